// ===== rtl/core/pfsa_pkg.sv =====
// Package for the PFSA forward log-likelihood scorer: payload structs,
// function codes, controller states and command/status structs. No dependencies.
`default_nettype none
package pfsa_pkg;
  localparam int unsigned N_STATES = 16;
  localparam int unsigned N_SYMBOLS = 8;
  localparam int unsigned PROB_FRAC_BITS = 16;
  localparam int unsigned LOG_FRAC = 16;
  localparam int unsigned COUNT_W = 20;
  localparam int unsigned MEAN_W = 22;

  typedef enum logic [1:0] {
    FN_MODEL = 2'd0,
    FN_INIT  = 2'd1,
    FN_SYM   = 2'd2,
    FN_END   = 2'd3
  } func_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  state_index;
    logic [2:0]  symbol_value;
    logic [3:0]  target_state;
    logic        target_valid;
    logic [16:0] probability;
  } in_item_t;

  typedef struct packed {
    logic [21:0] mean_neg_log2;
    logic [19:0] symbols_seen;
    logic        zero_prob_seen;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CLR,
    ST_ACC,
    ST_LOG,
    ST_NORM,
    ST_MEAN,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic latch_sym;   // capture the observed symbol of an accepted item
    logic start_load;  // copy initial weights, one state per cycle
    logic start_clr;   // clear scatter weights
    logic start_acc;   // walk states forming pr and scatter
    logic start_log;   // log2 by squaring
    logic start_norm;  // divide each weight by sum
    logic start_mean;  // divide accumulator by count
    logic sym_fin;     // commit accumulator and counter
    logic seq_reset;   // clear sequence state
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic sum_zero;
  } dp_status_t;
endpackage
`default_nettype wire

// ===== rtl/core/pfsa_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pfsa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/pfsa_datapath.sv =====
// Datapath of the PFSA scorer: model memories, weight registers, the
// multiply-accumulate walk, log2 and divider units. Uses pfsa_pkg and pfsa_ram.
`default_nettype none
module pfsa_datapath
  import pfsa_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire in_item_t   item,
  input  wire logic       wr_model,
  input  wire logic       wr_init,
  input  wire dp_cmd_t    cmd,
  output dp_status_t      status,
  output out_item_t       result
);
  localparam int unsigned SW = (N_STATES > 1) ? $clog2(N_STATES) : 1;
  localparam int unsigned AW = (N_SYMBOLS > 1) ? $clog2(N_SYMBOLS) : 1;
  localparam int unsigned EW = SW + AW;
  localparam int unsigned PW = PROB_FRAC_BITS + 1;
  localparam int unsigned TW = 2 * PW;                 // one product
  localparam int unsigned XW = TW + SW;                // sum of products
  localparam int unsigned NSW = SW + 1;
  localparam int unsigned CW = SW + 1;                 // state counter
  localparam int unsigned EXPW = $clog2(XW) + 1;
  localparam logic [PW-1:0] PROB_ONE = PW'(1) << PROB_FRAC_BITS;

  // Clamp and index of incoming writes.
  logic [PW-1:0] p_clamp;
  logic [16:0] p_in;
  logic st_ok, sym_ok, tgt_ok;
  always_comb begin
    p_in = item.probability;
    if (32'(p_in) > 32'(PROB_ONE)) p_clamp = PROB_ONE;
    else p_clamp = PW'(p_in);
    st_ok  = 32'(item.state_index) < N_STATES;
    sym_ok = 32'(item.symbol_value) < N_SYMBOLS;
    tgt_ok = 32'(item.target_state) < N_STATES;
  end

  // Walk counter shared by all sweeps.
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] st_idx;
  assign st_idx = cnt_r[SW-1:0];

  logic [AW-1:0] sym_r;
  logic sym_bad_r;
  logic [EW-1:0] raddr;
  logic [EW-1:0] waddr;
  assign raddr = {st_idx, sym_r};
  assign waddr = {item.state_index[SW-1:0], item.symbol_value[AW-1:0]};

  logic [PW-1:0] ep_q;
  logic [NSW-1:0] ns_q;
  logic mwe;
  assign mwe = wr_model && st_ok && sym_ok;
  pfsa_ram #(.WIDTH(PW), .DEPTH(N_STATES * N_SYMBOLS)) u_ep (
    .clk(clk), .we(mwe), .waddr(waddr), .wdata(p_clamp), .raddr(raddr), .rdata(ep_q)
  );
  pfsa_ram #(.WIDTH(NSW), .DEPTH(N_STATES * N_SYMBOLS)) u_ns (
    .clk(clk), .we(mwe), .waddr(waddr),
    .wdata((item.target_valid && tgt_ok) ? {1'b1, item.target_state[SW-1:0]} : '0),
    .raddr(raddr), .rdata(ns_q)
  );

  logic [PW-1:0] iw_q;
  pfsa_ram #(.WIDTH(PW), .DEPTH(N_STATES)) u_iw (
    .clk(clk), .we(wr_init && st_ok), .waddr(item.state_index[SW-1:0]),
    .wdata(p_clamp), .raddr(st_idx), .rdata(iw_q)
  );

  logic [PW-1:0] cw_r [N_STATES];
  logic [XW-1:0] sc_r [N_STATES];
  logic [XW-1:0] pr_r, sum_r;
  logic [TW-1:0] prod_r;
  logic [SW-1:0] prod_tgt_r;
  logic prod_v_r, prod_tv_r;
  logic signed [31:0] acc_r;
  logic [COUNT_W-1:0] cnt_sym_r;
  logic zflag_r;

  typedef enum logic [2:0] {
    U_NONE, U_LOAD, U_CLR, U_ACC, U_LOG, U_NORM, U_MEAN
  } unit_t;
  logic [2:0] unit_r;
  logic busy_r, done_r;

  // Log2 unit state.
  logic [31:0] m_r;
  logic [LOG_FRAC-1:0] frac_r;
  logic signed [EXPW:0] e_r;
  logic [4:0] lstep_r;
  logic signed [31:0] lg_r;
  logic [63:0] sq;
  assign sq = 64'(m_r) * 64'(m_r);

  // Normalizing restoring divider: num/den -> PW quotient bits.
  logic [XW:0] rem_r;
  logic [XW-1:0] den_r;
  logic [31:0] quo_r;
  logic [5:0] dstep_r;
  logic [XW:0] rem_sh;
  assign rem_sh = rem_r;

  // Mean divider: 32-bit dividend by count, bit serial.
  logic [31:0] mnum_r;
  logic [COUNT_W:0] mrem_r;
  logic [31:0] mq_r;
  logic [21:0] mean_r;

  // Count and flag of the finished sequence, held with the mean.
  logic [COUNT_W-1:0] res_cnt_r;
  logic res_zero_r;

  // Leading one of pr (combinational search over XW bits at a fixed width).
  logic [EXPW-1:0] lead;
  always_comb begin
    lead = '0;
    for (int i = 0; i < XW; i++) begin
      if (pr_r[i]) lead = EXPW'(i);
    end
  end

  logic [31:0] mant0;
  always_comb begin
    if (32'(lead) >= 31) mant0 = 32'(pr_r >> (32'(lead) - 31));
    else mant0 = 32'(pr_r) << (31 - 32'(lead));
  end

  logic signed [33:0] acc_sum;
  assign acc_sum = 34'(acc_r) + 34'(lg_r);

  assign status.done = done_r;
  assign status.sum_zero = (sum_r == '0);
  assign result.mean_neg_log2 = mean_r;
  assign result.symbols_seen = res_cnt_r;
  assign result.zero_prob_seen = res_zero_r;

  always_comb begin
    cnt_nxt = cnt_r + CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      unit_r <= U_NONE;
      acc_r <= '0;
      cnt_sym_r <= '0;
      zflag_r <= 1'b0;
      prod_v_r <= 1'b0;
      for (int i = 0; i < N_STATES; i++) cw_r[i] <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.latch_sym) begin
        sym_r <= item.symbol_value[AW-1:0];
        sym_bad_r <= !sym_ok;
      end
      if (cmd.start_load || cmd.start_clr || cmd.start_acc || cmd.start_norm) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
        prod_v_r <= 1'b0;
        unit_r <= cmd.start_load ? U_LOAD : cmd.start_clr ? U_CLR :
                  cmd.start_acc ? U_ACC : U_NORM;
        if (cmd.start_acc) begin
          pr_r <= '0;
          sum_r <= '0;
        end
        if (cmd.start_norm) dstep_r <= '0;
      end else if (cmd.start_log) begin
        busy_r <= 1'b1;
        unit_r <= U_LOG;
        m_r <= mant0;
        e_r <= $signed({1'b0, lead}) - (EXPW+1)'(2 * PROB_FRAC_BITS);
        frac_r <= '0;
        lstep_r <= '0;
      end else if (cmd.start_mean) begin
        busy_r <= 1'b1;
        unit_r <= U_MEAN;
        mnum_r <= (acc_r < 0) ? 32'(-34'(acc_r)) : '0;
        mrem_r <= '0;
        mq_r <= '0;
        dstep_r <= '0;
      end else if (busy_r) begin
        case (unit_r)
          U_LOAD: begin
            // RAM read data is registered: write index cnt-1.
            if (cnt_r != '0) cw_r[SW'(cnt_r - CW'(1))] <= iw_q;
            if (32'(cnt_r) == N_STATES) begin busy_r <= 1'b0; done_r <= 1'b1; end
            else cnt_r <= cnt_nxt;
          end
          U_CLR: begin
            for (int i = 0; i < N_STATES; i++) sc_r[i] <= '0;
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
          U_ACC: begin
            // Stage 1: multiply the entry read last cycle; stage 2: accumulate.
            if (cnt_r != '0 && 32'(cnt_r) <= N_STATES) begin
              prod_r <= sym_bad_r ? '0 : TW'(cw_r[SW'(cnt_r - CW'(1))]) * TW'(ep_q);
              prod_tgt_r <= ns_q[SW-1:0];
              prod_tv_r <= ns_q[SW] && !sym_bad_r;
              prod_v_r <= 1'b1;
            end else prod_v_r <= 1'b0;
            if (prod_v_r) begin
              pr_r <= pr_r + XW'(prod_r);
              if (prod_tv_r) begin
                sc_r[prod_tgt_r] <= sc_r[prod_tgt_r] + XW'(prod_r);
                sum_r <= sum_r + XW'(prod_r);
              end
            end
            if (32'(cnt_r) == N_STATES + 1) begin busy_r <= 1'b0; done_r <= 1'b1; end
            else cnt_r <= cnt_nxt;
          end
          U_LOG: begin
            if (32'(lstep_r) == LOG_FRAC) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
              if (pr_r == '0) begin
                lg_r <= -(32'sd32 <<< LOG_FRAC);
                zflag_r <= 1'b1;
              end else if ((32'(e_r) <<< LOG_FRAC) + $signed(32'(frac_r))
                           < -(32'sd32 <<< LOG_FRAC)) begin
                lg_r <= -(32'sd32 <<< LOG_FRAC);
              end else begin
                lg_r <= (32'(e_r) <<< LOG_FRAC) + $signed(32'(frac_r));
              end
            end else begin
              lstep_r <= lstep_r + 5'd1;
              if (sq[63]) begin
                m_r <= sq[63:32];
                frac_r <= {frac_r[LOG_FRAC-2:0], 1'b1};
              end else begin
                m_r <= sq[62:31];
                frac_r <= {frac_r[LOG_FRAC-2:0], 1'b0};
              end
            end
          end
          U_NORM: begin
            // One quotient bit per cycle, PROB_FRAC_BITS+1 bits per state.
            if (dstep_r == '0) begin
              rem_r <= {1'b0, sc_r[st_idx]};
              den_r <= sum_r;
              quo_r <= '0;
              dstep_r <= 6'd1;
            end else if (32'(dstep_r) <= PW) begin
              if (rem_sh >= {1'b0, den_r}) begin
                rem_r <= (rem_sh - {1'b0, den_r}) << 1;
                quo_r <= {quo_r[30:0], 1'b1};
              end else begin
                rem_r <= rem_sh << 1;
                quo_r <= {quo_r[30:0], 1'b0};
              end
              dstep_r <= dstep_r + 6'd1;
            end else begin
              cw_r[st_idx] <= PW'(quo_r);
              dstep_r <= '0;
              if (32'(cnt_r) == N_STATES - 1) begin busy_r <= 1'b0; done_r <= 1'b1; end
              else cnt_r <= cnt_nxt;
            end
          end
          U_MEAN: begin
            if (dstep_r == 6'd32 || cnt_sym_r == '0) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
              res_cnt_r <= cnt_sym_r;
              res_zero_r <= zflag_r;
              if (cnt_sym_r == '0) mean_r <= '0;
              else if (mq_r > (32'd32 << LOG_FRAC)) mean_r <= 22'(32'd32 << LOG_FRAC);
              else mean_r <= mq_r[21:0];
            end else begin
              if ({mrem_r[COUNT_W-1:0], mnum_r[31]} >= {1'b0, cnt_sym_r}) begin
                mrem_r <= {mrem_r[COUNT_W-1:0], mnum_r[31]} - {1'b0, cnt_sym_r};
                mq_r <= {mq_r[30:0], 1'b1};
              end else begin
                mrem_r <= {mrem_r[COUNT_W-1:0], mnum_r[31]};
                mq_r <= {mq_r[30:0], 1'b0};
              end
              mnum_r <= {mnum_r[30:0], 1'b0};
              dstep_r <= dstep_r + 6'd1;
            end
          end
          default: busy_r <= 1'b0;
        endcase
      end
      if (cmd.sym_fin) begin
        if (acc_sum > 34'sd2147483647) acc_r <= 32'sh7fffffff;
        else if (acc_sum < -34'sd2147483648) acc_r <= 32'sh80000000;
        else acc_r <= acc_sum[31:0];
        if (cnt_sym_r != '1) cnt_sym_r <= cnt_sym_r + COUNT_W'(1);
      end
      if (cmd.seq_reset) begin
        acc_r <= '0;
        cnt_sym_r <= '0;
        zflag_r <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/pfsa_ctrl.sv =====
// Controller of the PFSA scorer: sequences the datapath units per item
// and runs the handshakes. Uses pfsa_pkg.
`default_nettype none
module pfsa_ctrl
  import pfsa_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_item_t   in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            wr_model,
  output logic            wr_init,
  output dp_cmd_t         cmd,
  input  wire dp_status_t status
);
  ctrl_state_t state_r, state_nxt;
  logic fresh_r, fresh_nxt;
  logic ov_r, ov_nxt;
  logic acc_in;

  // Only an end item has to wait for a pending result to be transferred.
  assign in_stall = (state_r != ST_IDLE) || (ov_r && (in_data.func == FN_END));
  assign acc_in = in_valid && !in_stall;
  assign out_valid = ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fresh_r <= 1'b1;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fresh_r <= fresh_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    fresh_nxt = fresh_r;
    ov_nxt = ov_r && out_stall;
    cmd = '0;
    wr_model = 1'b0;
    wr_init = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (acc_in) begin
          case (in_data.func)
            FN_MODEL: wr_model = 1'b1;
            FN_INIT:  wr_init = 1'b1;
            FN_SYM: begin
              cmd.latch_sym = 1'b1;
              if (fresh_r) begin
                cmd.start_load = 1'b1;
                state_nxt = ST_LOAD;
              end else begin
                cmd.start_clr = 1'b1;
                state_nxt = ST_CLR;
              end
            end
            default: begin
              cmd.start_mean = 1'b1;
              state_nxt = ST_MEAN;
            end
          endcase
        end
      end
      ST_LOAD: if (status.done) begin
        fresh_nxt = 1'b0;
        cmd.start_clr = 1'b1;
        state_nxt = ST_CLR;
      end
      ST_CLR: if (status.done) begin
        cmd.start_acc = 1'b1;
        state_nxt = ST_ACC;
      end
      ST_ACC: if (status.done) begin
        cmd.start_log = 1'b1;
        state_nxt = ST_LOG;
      end
      ST_LOG: if (status.done) begin
        cmd.sym_fin = 1'b1;
        if (status.sum_zero) state_nxt = ST_IDLE;
        else begin
          cmd.start_norm = 1'b1;
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: if (status.done) state_nxt = ST_IDLE;
      ST_MEAN: if (status.done) begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        ov_nxt = 1'b1;
        cmd.seq_reset = 1'b1;
        fresh_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/core/pfsa_sequence_log_likelihood_top.sv =====
// Top level of the PFSA forward log-likelihood scorer.
// Joins pfsa_ctrl and pfsa_datapath; uses pfsa_pkg.
//
// Usage: one input channel (in_valid, in_stall, in_data) carries model
// writes, initial weight writes, observed symbols and end-of-sequence
// items. Only an end item produces a transfer on the result channel
// (out_valid, out_stall, out_data) carrying the mean negative log2
// likelihood, the symbol count and the zero-probability flag.
// Sequencing: a model or weight write leaves the controller idle, so the
// next item may follow in the next cycle. A symbol whose weights reach no
// next state holds the input through the clear, the pipelined multiply
// walk and the log2 squaring loop. Otherwise the bit-serial normalizing
// divider follows. The first symbol of each sequence first loads the
// initial weights. An end item offers its result after the 32-step
// bit-serial mean divider, which an empty sequence skips.
// Reset: rst_n is synchronous, active low; it clears the symbol counter,
// flags and weights. Model memories hold nothing defined until written.
// When the receiver stalls, the result holds in its output register. Model
// writes and symbols are still taken meanwhile; the next end item is held
// off until the pending result is transferred.
`default_nettype none
module pfsa_sequence_log_likelihood_top
  import pfsa_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);
  dp_cmd_t cmd;
  dp_status_t status;
  logic wr_model, wr_init;

  pfsa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .wr_model(wr_model), .wr_init(wr_init), .cmd(cmd), .status(status)
  );

  // The result registers inside the datapath change only when the mean unit
  // runs, which needs an end item that waits until out_valid has dropped.
  pfsa_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .item(in_data),
    .wr_model(wr_model), .wr_init(wr_init),
    .cmd(cmd), .status(status), .result(out_data)
  );
endmodule
`default_nettype wire

// ===== test/tb_pfsa_sequence_log_likelihood_top.sv =====
// Testbench for the PFSA forward log-likelihood scorer top level.
// Predicts each end-of-sequence result with a scoreboard class; uses pfsa_pkg.
`default_nettype none
module tb_pfsa_sequence_log_likelihood_top;
  import pfsa_pkg::*;

  localparam int NST = 16;
  localparam int NSYM = 8;
  localparam int FRAC = 16;
  localparam int LOGF = 16;
  localparam longint LOG_FLOOR = -(64'sd32 <<< LOGF);
  localparam longint MEAN_MAX = 64'sd32 <<< LOGF;
  localparam int CYCLE_LIMIT = 3000000;

  // Scoreboard: keeps its own copy of the model and the forward weights and
  // queues the score expected for every end-of-sequence transfer.
  class likelihood_scoreboard;
    bit [16:0] emis [NST*NSYM];
    bit        nvalid [NST*NSYM];
    bit [3:0]  ntgt [NST*NSYM];
    bit [16:0] init_w [NST];
    bit [16:0] cur_w [NST];
    longint    log_acc;
    int        sym_count;
    bit        zero_seen;
    bit        fresh;
    out_item_t score_q[$];
    int        errors;

    function new();
      for (int i = 0; i < NST*NSYM; i++) begin
        emis[i] = 0; nvalid[i] = 0; ntgt[i] = 0;
      end
      for (int i = 0; i < NST; i++) begin
        init_w[i] = 0; cur_w[i] = 0;
      end
      log_acc = 0; sym_count = 0; zero_seen = 0; fresh = 1; errors = 0;
    endfunction

    // Log2 of x / 2^(2F) in Q.16 by mantissa squaring, floored at -32.
    function longint log2_fixed(longint unsigned x);
      int e;
      longint unsigned m;
      longint fr;
      longint r;
      e = 63; fr = 0;
      while (e > 0 && x[e] == 1'b0) e--;
      if (e >= 31) m = x >> (e - 31);
      else m = x << (31 - e);
      for (int i = 0; i < LOGF; i++) begin
        m = (m * m) >> 31;
        fr = fr << 1;
        if (m >= (64'd2 << 31)) begin
          m = m >> 1;
          fr = fr | 1;
        end
      end
      r = longint'(e - 2*FRAC) * (64'sd1 <<< LOGF) + fr;
      return (r < LOG_FLOOR) ? LOG_FLOOR : r;
    endfunction

    function bit [16:0] normalize(longint unsigned num, longint unsigned den);
      longint unsigned q, r;
      q = 0; r = num;
      for (int i = 0; i <= FRAC; i++) begin
        q = q << 1;
        if (r >= den) begin
          r = r - den;
          q = q | 1;
        end
        r = r << 1;
      end
      return q[16:0];
    endfunction

    function void note_input(in_item_t it);
      bit [16:0] p;
      int idx;
      longint unsigned pr, sum, t;
      longint unsigned scat [NST];
      longint lg;
      out_item_t o;
      longint unsigned mean;
      p = (it.probability > 17'd65536) ? 17'd65536 : it.probability;
      case (func_t'(it.func))
        FN_MODEL: begin
          idx = it.state_index * NSYM + it.symbol_value;
          emis[idx] = p;
          nvalid[idx] = it.target_valid;
          ntgt[idx] = it.target_state;
        end
        FN_INIT: init_w[it.state_index] = p;
        FN_SYM: begin
          if (fresh) begin
            cur_w = init_w;
            fresh = 0;
          end
          pr = 0; sum = 0;
          for (int s = 0; s < NST; s++) scat[s] = 0;
          for (int s = 0; s < NST; s++) begin
            idx = s * NSYM + it.symbol_value;
            t = longint'(cur_w[s]) * longint'(emis[idx]);
            pr += t;
            if (nvalid[idx]) begin
              scat[ntgt[idx]] += t;
              sum += t;
            end
          end
          if (pr == 0) begin
            lg = LOG_FLOOR;
            zero_seen = 1;
          end else begin
            lg = log2_fixed(pr);
          end
          log_acc += lg;
          if (log_acc > 64'sd2147483647) log_acc = 64'sd2147483647;
          if (log_acc < -64'sd2147483648) log_acc = -64'sd2147483648;
          if (sym_count < 1048575) sym_count++;
          if (sum != 0)
            for (int s = 0; s < NST; s++) cur_w[s] = normalize(scat[s], sum);
        end
        FN_END: begin
          mean = 0;
          if (sym_count != 0 && log_acc < 0) begin
            mean = longint'(-log_acc) / sym_count;
            if (mean > MEAN_MAX) mean = MEAN_MAX;
          end
          o.mean_neg_log2 = mean[21:0];
          o.symbols_seen = sym_count[19:0];
          o.zero_prob_seen = zero_seen;
          score_q.insert(score_q.size(), o);
          log_acc = 0; sym_count = 0; zero_seen = 0;
          cur_w = init_w;
          fresh = 1;
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_o;
      if (score_q.size() == 0) begin
        $error("unexpected result transfer %h", got);
        errors++;
        return;
      end
      exp_o = score_q.pop_front();
      if (got.mean_neg_log2 !== exp_o.mean_neg_log2) begin
        $error("mean_neg_log2 expected %0d actual %0d",
               exp_o.mean_neg_log2, got.mean_neg_log2);
        errors++;
      end
      if (got.symbols_seen !== exp_o.symbols_seen) begin
        $error("symbols_seen expected %0d actual %0d",
               exp_o.symbols_seen, got.symbols_seen);
        errors++;
      end
      if (got.zero_prob_seen !== exp_o.zero_prob_seen) begin
        $error("zero_prob_seen expected %0d actual %0d",
               exp_o.zero_prob_seen, got.zero_prob_seen);
        errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  likelihood_scoreboard sb;

  // Idle percentages for the two sides; hold_off forces a long stall.
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_off = 1'b0;
  int  cycle_count = 0;

  pfsa_sequence_log_likelihood_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Reset is asserted once, at the start of the run.
  initial begin
    rst_n = 1'b0;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // The receiver stalls at random, or solidly while hold_off is set.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Every accepted result transfer is checked against the oldest score.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Offers one item, with a random gap first, and waits for its transfer.
  // The scoreboard sees it on the edge that accepts it. Valid stays high
  // after the transfer until the next item, a gap or a drain replaces it.
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(it);
  endtask

  function automatic in_item_t make_item(func_t f, int st, int sym, int tgt, int tv,
                                         int p);
    in_item_t it;
    it.func = f;
    it.state_index = 4'(st);
    it.symbol_value = 3'(sym);
    it.target_state = 4'(tgt);
    it.target_valid = 1'(tv);
    it.probability = 17'(p);
    return it;
  endfunction

  // Waits until every expected result has arrived plus a settling pause
  // long enough for a symbol still in flight.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.score_q.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
  endtask

  // Writes a random initial distribution.
  task automatic load_init();
    for (int s = 0; s < NST; s++)
      send_item(make_item(FN_INIT, s, $urandom_range(7), $urandom_range(15),
                          $urandom_range(1), $urandom_range(4096)));
  endtask

  // Loads a full random model and a random initial distribution. Sparse
  // rows and absent transitions appear now and then; probabilities above
  // one are sometimes written to exercise the clamp.
  task automatic load_model();
    int p, r;
    for (int s = 0; s < NST; s++)
      for (int y = 0; y < NSYM; y++) begin
        r = $urandom_range(99);
        if (r < 8) p = 0;
        else if (r < 12) p = $urandom_range(131071);
        else if (r < 15) p = $urandom_range(3);
        else p = $urandom_range(65536);
        send_item(make_item(FN_MODEL, s, y, $urandom_range(15),
                            32'($urandom_range(99) < 85), p));
      end
    load_init();
  endtask

  // A sequence of random symbols, closed by an end item.
  task automatic send_sequence(int len);
    for (int i = 0; i < len; i++)
      send_item(make_item(FN_SYM, $urandom_range(15), $urandom_range(7),
                          $urandom_range(15), $urandom_range(1),
                          $urandom_range(131071)));
    send_item(make_item(FN_END, $urandom_range(15), $urandom_range(7),
                        $urandom_range(15), $urandom_range(1),
                        $urandom_range(131071)));
  endtask

  int r;

  initial begin
    @(posedge rst_n);
    @(posedge clk);

    // Directed part: end of an empty sequence, then a tiny model with a
    // dead state that gives zero probability, full-scale weights and
    // an entry written without a valid target, stored as no transition.
    load_model();
    send_item(make_item(FN_END, 0, 0, 0, 0, 0));
    send_item(make_item(FN_MODEL, 0, 0, 15, 0, 131071));
    send_item(make_item(FN_MODEL, 15, 7, 0, 1, 65536));
    send_item(make_item(FN_MODEL, 3, 2, 3, 1, 0));
    send_item(make_item(FN_INIT, 0, 0, 0, 0, 131071));
    send_item(make_item(FN_INIT, 15, 7, 15, 1, 65536));
    send_item(make_item(FN_SYM, 0, 0, 0, 0, 0));
    send_item(make_item(FN_SYM, 15, 7, 15, 1, 131071));
    send_item(make_item(FN_END, 0, 0, 0, 0, 0));
    // All weights zero: every symbol has zero probability, weights kept.
    for (int s = 0; s < NST; s++) send_item(make_item(FN_INIT, s, 0, 0, 0, 0));
    send_item(make_item(FN_SYM, 0, 3, 0, 0, 0));
    send_item(make_item(FN_SYM, 0, 5, 0, 0, 0));
    send_item(make_item(FN_END, 0, 0, 0, 0, 0));
    // Tiny weights and probabilities push log2 toward its floor.
    for (int s = 0; s < NST; s++) send_item(make_item(FN_INIT, s, 0, 0, 0, 1));
    for (int y = 0; y < NSYM; y++) send_item(make_item(FN_MODEL, 1, y, 1, 1, 1));
    send_item(make_item(FN_SYM, 0, 1, 0, 0, 0));
    send_item(make_item(FN_END, 0, 0, 0, 0, 0));
    drain();

    // Random part in idling phases; each phase reloads the initial weights.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      load_init();
      for (int k = 0; k < 14; k++) begin
        r = $urandom_range(99);
        if (r < 60) send_sequence($urandom_range(1, 4));
        else if (r < 90) send_sequence($urandom_range(0, 1));
        else send_item(make_item(FN_MODEL, $urandom_range(15), $urandom_range(7),
                                 $urandom_range(15), $urandom_range(1),
                                 $urandom_range(131071)));
      end
      // The sender pauses until every expected result has come.
      drain();
    end

    // Long hold-off on the receiver while the sender keeps offering end
    // items, so the result register fills and the input stalls.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (2000) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int k = 0; k < 6; k++) send_sequence(1);
      end
    join

    drain();
    if (sb.errors == 0 && sb.score_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/core/pfsa_pkg.sv
rtl/core/pfsa_ram.sv
rtl/core/pfsa_datapath.sv
rtl/core/pfsa_ctrl.sv
rtl/core/pfsa_sequence_log_likelihood_top.sv
test/tb_pfsa_sequence_log_likelihood_top.sv
